// ===== hw/rtl/dvrt_pkg.sv =====
// Shared types, codes and constants of the distance-vector route table.
package dvrt_pkg;

  localparam int unsigned NodesDefault = 16;
  localparam int unsigned CmdDepth     = 2;
  localparam logic [7:0]  NoNode       = 8'hFF;

  typedef enum logic [1:0] {
    REG_MY_NODE      = 2'd0,
    REG_EXPIRE_LIMIT = 2'd1,
    REG_COST_INF     = 2'd2
  } dvrt_reg_e;

  typedef enum logic [2:0] {
    ACT_HEARD  = 3'd0,
    ACT_ADV    = 3'd1,
    ACT_AGE    = 3'd2,
    ACT_LOOKUP = 3'd3,
    ACT_DUMP   = 3'd4
  } dvrt_action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LOCAL    = 2'd1,
    ST_NO_ROUTE = 2'd2,
    ST_REJECT   = 2'd3
  } dvrt_status_e;

  typedef enum logic [2:0] {
    OP_REPLY  = 3'd0,
    OP_HEARD  = 3'd1,
    OP_ADV    = 3'd2,
    OP_AGE    = 3'd3,
    OP_LOOKUP = 3'd4,
    OP_DUMP   = 3'd5
  } dvrt_op_e;

  typedef enum logic [3:0] {
    S_IDLE      = 4'd0,
    S_EXEC      = 4'd1,
    S_AGE_RD    = 4'd2,
    S_AGE_EX    = 4'd3,
    S_AGE_OUT   = 4'd4,
    S_DUMP_SELF = 4'd5,
    S_DUMP_RD   = 4'd6,
    S_DUMP_EX   = 4'd7
  } dvrt_state_e;

  typedef struct packed {
    logic [7:0] my_node;
    logic [7:0] expire_limit;
    logic [7:0] cost_inf;
  } dvrt_cfg_t;

  // Work handed from the classifier to the table engine.
  typedef struct packed {
    dvrt_op_e     op;
    logic [7:0]   node;    // table entry to touch
    logic [7:0]   hop;     // next hop to install, or reply next hop
    logic [7:0]   cost;    // cost to install, or reply cost
    dvrt_status_e status;  // reply status
  } dvrt_cmd_t;

  typedef struct packed {
    logic [7:0] hop;
    logic [7:0] cost;
    logic [7:0] age;
  } dvrt_route_t;

  typedef struct packed {
    dvrt_status_e status;
    logic [7:0]   fwd_hop;
    logic [7:0]   route_node;
    logic [7:0]   route_cost;
    logic         learned;
    logic [4:0]   expired_count;
    logic         last;
  } dvrt_res_t;

endpackage

// ===== hw/rtl/dvrt_front.sv =====
// Input stage: accepts items and classifies them into table commands.
module dvrt_front #(
  parameter int unsigned NODES = dvrt_pkg::NodesDefault
) (
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic [2:0]          action_i,
  input  logic [7:0]          sender_i,
  input  logic [7:0]          dest_i,
  input  logic [7:0]          adv_cost_i,
  input  logic                neighbor_alive_i,
  input  dvrt_pkg::dvrt_cfg_t cfg_i,
  input  logic                full_i,
  output logic                push_o,
  output dvrt_pkg::dvrt_cmd_t cmd_o
);

  localparam logic [7:0] NodeLimit = 8'(NODES);

  logic       src_bad;
  logic       dst_bad;
  logic [7:0] relaxed_cost;

  assign s_ready_o = !full_i;
  assign push_o    = s_valid_i && !full_i;

  assign src_bad  = (sender_i >= NodeLimit) || (sender_i == cfg_i.my_node);
  assign dst_bad  = (dest_i >= NodeLimit);
  // An advertised cost that wraps past 255 becomes unreachable.
  assign relaxed_cost = (adv_cost_i == 8'hFF) ? cfg_i.cost_inf : adv_cost_i + 8'd1;

  always_comb begin
    cmd_o        = '0;
    cmd_o.op     = dvrt_pkg::OP_REPLY;
    cmd_o.status = dvrt_pkg::ST_REJECT;
    case (action_i)
      dvrt_pkg::ACT_HEARD: begin
        if (!src_bad) begin
          cmd_o.op   = dvrt_pkg::OP_HEARD;
          cmd_o.node = sender_i;
        end
      end
      dvrt_pkg::ACT_ADV: begin
        if (!src_bad) begin
          if (dst_bad || dest_i == cfg_i.my_node || dest_i == sender_i ||
              adv_cost_i == cfg_i.cost_inf) begin
            cmd_o.status = dvrt_pkg::ST_OK;
          end else begin
            cmd_o.op   = dvrt_pkg::OP_ADV;
            cmd_o.node = dest_i;
            cmd_o.hop  = sender_i;
            cmd_o.cost = relaxed_cost;
          end
        end
      end
      dvrt_pkg::ACT_AGE: begin
        cmd_o.op = dvrt_pkg::OP_AGE;
      end
      dvrt_pkg::ACT_LOOKUP: begin
        if (dst_bad || cfg_i.my_node == dvrt_pkg::NoNode) begin
          cmd_o.hop = dvrt_pkg::NoNode;
        end else if (dest_i == cfg_i.my_node) begin
          cmd_o.status = dvrt_pkg::ST_LOCAL;
          cmd_o.hop    = cfg_i.my_node;
        end else if (neighbor_alive_i) begin
          cmd_o.status = dvrt_pkg::ST_OK;
          cmd_o.hop    = dest_i;
          cmd_o.cost   = 8'd1;
        end else begin
          cmd_o.op   = dvrt_pkg::OP_LOOKUP;
          cmd_o.node = dest_i;
        end
      end
      dvrt_pkg::ACT_DUMP: begin
        if (cfg_i.my_node != dvrt_pkg::NoNode) begin
          cmd_o.op = dvrt_pkg::OP_DUMP;
        end
      end
      default: begin
        cmd_o.op     = dvrt_pkg::OP_REPLY;
        cmd_o.status = dvrt_pkg::ST_REJECT;
      end
    endcase
  end

endmodule

// ===== hw/rtl/dvrt_cmd_fifo.sv =====
// Short command queue between the classifier and the table engine.
module dvrt_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dvrt_pkg::dvrt_cmd_t cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output dvrt_pkg::dvrt_cmd_t cmd_o
);

  localparam int unsigned PtrW = (dvrt_pkg::CmdDepth > 1) ? $clog2(dvrt_pkg::CmdDepth) : 1;
  localparam int unsigned CntW = $clog2(dvrt_pkg::CmdDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(dvrt_pkg::CmdDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(dvrt_pkg::CmdDepth);

  dvrt_pkg::dvrt_cmd_t slot_q [dvrt_pkg::CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : PtrW'(wr_ptr_q + PtrW'(1));
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : PtrW'(rd_ptr_q + PtrW'(1));
    end
    if (do_push && !do_pop) begin
      count_d = CntW'(count_q + CntW'(1));
    end else if (do_pop && !do_push) begin
      count_d = CntW'(count_q - CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== hw/rtl/dvrt_back.sv =====
// Table engine: route memory, entry walker and result register.
module dvrt_back #(
  parameter int unsigned NODES = dvrt_pkg::NodesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dvrt_pkg::dvrt_cfg_t cfg_i,
  input  logic                empty_i,
  input  dvrt_pkg::dvrt_cmd_t cmd_i,
  output logic                pop_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output dvrt_pkg::dvrt_res_t res_o
);

  localparam int unsigned IdxW = $clog2(NODES);
  localparam int unsigned ExpW = $clog2(NODES + 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(NODES - 1);
  localparam logic [IdxW-1:0] DumpLast = IdxW'(NODES - 2);

  dvrt_pkg::dvrt_state_e state_q, state_d;
  dvrt_pkg::dvrt_cmd_t   cmd_q, cmd_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [IdxW-1:0]       cnt_q, cnt_d;
  logic [ExpW-1:0]       exp_q, exp_d;
  logic [NODES-1:0]      valid_q, valid_d;

  dvrt_pkg::dvrt_route_t route_mem_q [NODES];
  dvrt_pkg::dvrt_route_t rdata_q;
  logic                  rd_en;
  logic [IdxW-1:0]       rd_addr;
  logic                  wr_en;
  logic [IdxW-1:0]       wr_addr;
  dvrt_pkg::dvrt_route_t wr_data;

  dvrt_pkg::dvrt_res_t   res_q, res_d;
  logic                  res_valid_q;
  logic                  emit;
  logic                  out_free;

  logic [IdxW-1:0]       ent;
  logic [7:0]            age_next;
  logic [NODES-1:0]      valid_up;
  logic                  more_valid;
  logic                  dump_last;

  assign out_free    = !res_valid_q || res_ready_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign ent        = cmd_q.node[IdxW-1:0];
  assign age_next   = (rdata_q.age == 8'hFF) ? 8'hFF : rdata_q.age + 8'd1;
  assign valid_up   = valid_q >> idx_q;
  assign more_valid = |valid_up[NODES-1:1];
  assign dump_last  = !more_valid || (cnt_q == DumpLast);

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    exp_d   = exp_q;
    valid_d = valid_q;
    pop_o   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = idx_q;
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = rdata_q;
    emit    = 1'b0;
    res_d   = '0;
    res_d.status = dvrt_pkg::ST_OK;

    case (state_q)
      dvrt_pkg::S_IDLE: begin
        if (!empty_i) begin
          case (cmd_i.op)
            dvrt_pkg::OP_REPLY: begin
              if (out_free) begin
                pop_o            = 1'b1;
                emit             = 1'b1;
                res_d.status     = cmd_i.status;
                res_d.fwd_hop    = cmd_i.hop;
                res_d.route_cost = cmd_i.cost;
                res_d.last       = 1'b1;
              end
            end
            dvrt_pkg::OP_HEARD, dvrt_pkg::OP_ADV, dvrt_pkg::OP_LOOKUP: begin
              pop_o   = 1'b1;
              cmd_d   = cmd_i;
              rd_en   = 1'b1;
              rd_addr = cmd_i.node[IdxW-1:0];
              state_d = dvrt_pkg::S_EXEC;
            end
            dvrt_pkg::OP_AGE: begin
              pop_o   = 1'b1;
              idx_d   = '0;
              exp_d   = '0;
              state_d = dvrt_pkg::S_AGE_RD;
            end
            dvrt_pkg::OP_DUMP: begin
              pop_o   = 1'b1;
              state_d = dvrt_pkg::S_DUMP_SELF;
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end

      dvrt_pkg::S_EXEC: begin
        if (out_free) begin
          emit       = 1'b1;
          res_d.last = 1'b1;
          state_d    = dvrt_pkg::S_IDLE;
          wr_addr    = ent;
          case (cmd_q.op)
            dvrt_pkg::OP_HEARD: begin
              wr_en = 1'b1;
              if (!valid_q[ent] || rdata_q.cost > 8'd1) begin
                wr_data      = '{hop: cmd_q.node, cost: 8'd1, age: 8'd0};
                valid_d[ent] = 1'b1;
              end else begin
                wr_data.age = 8'd0;
              end
            end
            dvrt_pkg::OP_ADV: begin
              wr_en = 1'b1;
              if (!valid_q[ent] || rdata_q.cost > cmd_q.cost) begin
                wr_data       = '{hop: cmd_q.hop, cost: cmd_q.cost, age: 8'd0};
                valid_d[ent]  = 1'b1;
                res_d.learned = 1'b1;
              end else begin
                wr_data.age = 8'd0;
              end
            end
            dvrt_pkg::OP_LOOKUP: begin
              if (valid_q[ent]) begin
                res_d.fwd_hop    = rdata_q.hop;
                res_d.route_cost = rdata_q.cost;
              end else begin
                res_d.status     = dvrt_pkg::ST_NO_ROUTE;
                res_d.fwd_hop    = dvrt_pkg::NoNode;
                res_d.route_cost = cfg_i.cost_inf;
              end
            end
            default: begin
              wr_en = 1'b0;
            end
          endcase
        end
      end

      dvrt_pkg::S_AGE_RD: begin
        if (valid_q[idx_q]) begin
          rd_en   = 1'b1;
          state_d = dvrt_pkg::S_AGE_EX;
        end else if (idx_q == IdxLast) begin
          state_d = dvrt_pkg::S_AGE_OUT;
        end else begin
          idx_d = IdxW'(idx_q + IdxW'(1));
        end
      end

      dvrt_pkg::S_AGE_EX: begin
        wr_en       = 1'b1;
        wr_data.age = age_next;
        // Expiry drops the valid bit; the incremented age is still written back.
        if (age_next > cfg_i.expire_limit) begin
          valid_d[idx_q] = 1'b0;
          exp_d          = ExpW'(exp_q + ExpW'(1));
        end
        if (idx_q == IdxLast) begin
          state_d = dvrt_pkg::S_AGE_OUT;
        end else begin
          idx_d   = IdxW'(idx_q + IdxW'(1));
          state_d = dvrt_pkg::S_AGE_RD;
        end
      end

      dvrt_pkg::S_AGE_OUT: begin
        if (out_free) begin
          emit                = 1'b1;
          res_d.expired_count = 5'(exp_q);
          res_d.last          = 1'b1;
          state_d             = dvrt_pkg::S_IDLE;
        end
      end

      dvrt_pkg::S_DUMP_SELF: begin
        if (out_free) begin
          emit             = 1'b1;
          res_d.route_node = cfg_i.my_node;
          res_d.last       = ~|valid_q;
          idx_d            = '0;
          cnt_d            = '0;
          state_d          = (~|valid_q) ? dvrt_pkg::S_IDLE : dvrt_pkg::S_DUMP_RD;
        end
      end

      dvrt_pkg::S_DUMP_RD: begin
        if (valid_q[idx_q]) begin
          rd_en   = 1'b1;
          state_d = dvrt_pkg::S_DUMP_EX;
        end else if (idx_q == IdxLast) begin
          state_d = dvrt_pkg::S_IDLE;
        end else begin
          idx_d = IdxW'(idx_q + IdxW'(1));
        end
      end

      dvrt_pkg::S_DUMP_EX: begin
        if (out_free) begin
          emit             = 1'b1;
          res_d.route_node = 8'(idx_q);
          res_d.route_cost = rdata_q.cost;
          res_d.last       = dump_last;
          if (dump_last) begin
            state_d = dvrt_pkg::S_IDLE;
          end else begin
            idx_d   = IdxW'(idx_q + IdxW'(1));
            cnt_d   = IdxW'(cnt_q + IdxW'(1));
            state_d = dvrt_pkg::S_DUMP_RD;
          end
        end
      end

      default: begin
        state_d = dvrt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dvrt_pkg::S_IDLE;
      valid_q     <= '0;
      res_valid_q <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
      exp_q       <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      exp_q   <= exp_d;
      if (emit) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (emit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      route_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= route_mem_q[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/distance_vector_route_table_unit.sv =====
// Top level of the distance-vector route table unit.
//
// This block keeps one route per destination node (valid, next hop, cost,
// age) and serves five item kinds arriving on the slave stream: neighbor
// heard, advertised entry (Bellman-Ford relaxation at the advertised cost
// plus one), age tick, lookup and table dump. The action code rides in
// s_axis_tuser; each result carries its status in m_axis_tuser and tlast
// marks the final result of an item. A classifier checks node ranges and
// configuration at the input and queues a command into a two-entry queue;
// the table engine behind it owns the route memory, whose single read port
// with registered data sets the pace. Items answered by the classifier alone
// (rejects, skipped advertisements, local or directly alive lookups) are
// replied to by the engine without a table read. Neighbor heard, advertised
// entry and a table lookup first read the entry, then update it and present
// the result. An age tick walks every entry, reading and writing back each
// valid one and passing over invalid ones, and then reports the expired
// count. A dump first presents the self entry, then walks the entries up to
// the last route it lists, reading each valid entry and passing over invalid
// ones, with one result transfer per listed route; with an empty table it
// ends after the self entry. The result register lets the next item be
// accepted and queued while a result waits. Configuration writes on the cfg
// channel are always taken and should be issued only while the unit is idle.
module distance_vector_route_table_unit #(
  parameter int unsigned NODES = dvrt_pkg::NodesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sender [7:0], dest [15:8], adv_cost [23:16], neighbor_alive [24]
  input  logic [31:0] s_axis_tdata,
  // action [2:0]
  input  logic [2:0]  s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // fwd_hop [7:0], route_node [15:8], route_cost [23:16], learned [24],
  // expired_count [29:25]
  output logic [31:0] m_axis_tdata,
  // status [1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [7:0]  cfg_data_i
);

  dvrt_pkg::dvrt_cfg_t cfg_q, cfg_d;
  dvrt_pkg::dvrt_cmd_t push_cmd;
  dvrt_pkg::dvrt_cmd_t head_cmd;
  dvrt_pkg::dvrt_res_t res;
  logic                cmd_push;
  logic                cmd_full;
  logic                cmd_pop;
  logic                cmd_empty;

  // Configuration registers; writes to unused indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_addr_i)
        dvrt_pkg::REG_MY_NODE:      cfg_d.my_node      = cfg_data_i;
        dvrt_pkg::REG_EXPIRE_LIMIT: cfg_d.expire_limit = cfg_data_i;
        dvrt_pkg::REG_COST_INF:     cfg_d.cost_inf     = cfg_data_i;
        default:                    cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.my_node      <= 8'd255;
      cfg_q.expire_limit <= 8'd5;
      cfg_q.cost_inf     <= 8'd255;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dvrt_front #(
    .NODES(NODES)
  ) u_front (
    .s_valid_i        (s_axis_tvalid),
    .s_ready_o        (s_axis_tready),
    .action_i         (s_axis_tuser),
    .sender_i         (s_axis_tdata[7:0]),
    .dest_i           (s_axis_tdata[15:8]),
    .adv_cost_i       (s_axis_tdata[23:16]),
    .neighbor_alive_i (s_axis_tdata[24]),
    .cfg_i            (cfg_q),
    .full_i           (cmd_full),
    .push_o           (cmd_push),
    .cmd_o            (push_cmd)
  );

  dvrt_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (push_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .cmd_o   (head_cmd)
  );

  dvrt_back #(
    .NODES(NODES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (cmd_empty),
    .cmd_i       (head_cmd),
    .pop_o       (cmd_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {2'b00, res.expired_count, res.learned, res.route_cost,
                         res.route_node, res.fwd_hop};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

  // A newly learned route is reported only in a single, successful result.
  a_learned_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.learned |-> m_axis_tlast && res.status == dvrt_pkg::ST_OK)
    else $error("learned flag on a non-final or failed result");

  // A missing route reports no next hop and the configured infinite cost.
  a_no_route_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status == dvrt_pkg::ST_NO_ROUTE |->
      res.fwd_hop == dvrt_pkg::NoNode && res.route_cost == cfg_q.cost_inf)
    else $error("no-route result with wrong next hop or cost");

  // Only dump entries come in runs; they carry no hop, flag or count.
  a_run_is_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |->
      res.status == dvrt_pkg::ST_OK && res.fwd_hop == 8'd0 &&
      !res.learned && res.expired_count == 5'd0)
    else $error("non-final result that is not a dump entry");

endmodule
